// File: hw/rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the settable time-of-day clock: the
// classified command that travels from the front end to the back end, its
// operation codes, and the ASCII codes and limits used on both sides.
// ----------------------------------------------------------------------------
package stc_pkg;

    // operation codes of a classified item
    typedef logic [2:0] t_op;
    localparam t_op OP_TICK   = 3'd0;
    localparam t_op OP_RESET  = 3'd1;
    localparam t_op OP_SET    = 3'd2;
    localparam t_op OP_TOGGLE = 3'd3;
    localparam t_op OP_ERROR  = 3'd4;

    // ascii codes
    localparam logic [7:0] CH_RESET  = 8'h52;
    localparam logic [7:0] CH_SET    = 8'h53;
    localparam logic [7:0] CH_TOGGLE = 8'h54;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // message lengths and time limits
    localparam logic [7:0] MIN_MSG_LEN = 8'd2;
    localparam logic [7:0] SET_MIN_LEN = 8'd11;
    localparam logic [4:0] MAX_HOUR    = 5'd23;
    localparam logic [5:0] MAX_MINUTE  = 6'd59;
    localparam logic [5:0] MAX_SECOND  = 6'd59;

    // classified item between front end and back end
    typedef struct packed {
        t_op        op;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_cmd;

endpackage

// File: hw/rtl/stc_front.sv
// ----------------------------------------------------------------------------
// stc_front
// Front end: classifies one input item into tick, reset, set, toggle or
// error, and converts the hh:mm:ss text of a set command to binary.
// ----------------------------------------------------------------------------
module stc_front (
    input  logic                 i_mode,
    input  logic [7:0]           i_message_length,
    input  logic [7:0]           i_command_char,
    input  logic [7:0]           i_hour_tens_char,
    input  logic [7:0]           i_hour_ones_char,
    input  logic [7:0]           i_first_separator,
    input  logic [7:0]           i_minute_tens_char,
    input  logic [7:0]           i_minute_ones_char,
    input  logic [7:0]           i_second_separator,
    input  logic [7:0]           i_second_tens_char,
    input  logic [7:0]           i_second_ones_char,
    output stc_pkg::t_cmd        o_cmd
);
    import stc_pkg::*;

    logic       fmt_ok;
    logic       range_ok;
    logic [6:0] hour_bin;
    logic [6:0] minute_bin;
    logic [6:0] second_bin;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // tens*10 + ones; only meaningful for digit characters
    function automatic logic [6:0] two_digits(input logic [7:0] t, input logic [7:0] o);
        return 7'(t[3:0]) * 7'd10 + 7'(o[3:0]);
    endfunction

    // text format of a set command
    assign fmt_ok = is_digit(i_hour_tens_char)   && is_digit(i_hour_ones_char)   &&
                    (i_first_separator == CH_COLON) &&
                    is_digit(i_minute_tens_char) && is_digit(i_minute_ones_char) &&
                    (i_second_separator == CH_COLON) &&
                    is_digit(i_second_tens_char) && is_digit(i_second_ones_char);

    assign hour_bin   = two_digits(i_hour_tens_char,   i_hour_ones_char);
    assign minute_bin = two_digits(i_minute_tens_char, i_minute_ones_char);
    assign second_bin = two_digits(i_second_tens_char, i_second_ones_char);

    assign range_ok = (hour_bin <= 7'(MAX_HOUR)) && (minute_bin <= 7'(MAX_MINUTE)) &&
                      (second_bin <= 7'(MAX_SECOND));

    // classify
    always_comb begin
        o_cmd.hour   = hour_bin[4:0];
        o_cmd.minute = minute_bin[5:0];
        o_cmd.second = second_bin[5:0];
        if (!i_mode) begin
            o_cmd.op = OP_TICK;
        end else if (i_message_length < MIN_MSG_LEN) begin
            o_cmd.op = OP_ERROR;
        end else begin
            case (i_command_char)
                CH_RESET:  o_cmd.op = OP_RESET;
                CH_TOGGLE: o_cmd.op = OP_TOGGLE;
                CH_SET: begin
                    if ((i_message_length >= SET_MIN_LEN) && fmt_ok && range_ok) begin
                        o_cmd.op = OP_SET;
                    end else begin
                        o_cmd.op = OP_ERROR;
                    end
                end
                default:   o_cmd.op = OP_ERROR;
            endcase
        end
    end

endmodule

// File: hw/rtl/stc_queue.sv
// ----------------------------------------------------------------------------
// stc_queue
// Short first-in first-out queue of classified commands between the front
// end and the back end.
// ----------------------------------------------------------------------------
module stc_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stc_pkg::t_cmd  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output stc_pkg::t_cmd  o_data
);
    import stc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = do_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hw/rtl/stc_back.sv
// ----------------------------------------------------------------------------
// stc_back
// Back end: holds the time and display flag, applies one classified command
// per cycle while its result slot is free or popped; registers status and HH:MM:SS text.
// ----------------------------------------------------------------------------
module stc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  stc_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_status,
    output logic [63:0]    o_display_text
);
    import stc_pkg::*;

    logic [4:0]  r_hour,   n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    logic        r_disp,   n_disp;
    logic        r_out_valid;
    logic        r_status;
    logic [63:0] r_text;
    logic        take;

    // two ascii digits of a value below 64
    function automatic logic [15:0] digit_pair(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] ones;
        if (v >= 6'd60) begin
            tens = 3'd6;
        end else if (v >= 6'd50) begin
            tens = 3'd5;
        end else if (v >= 6'd40) begin
            tens = 3'd4;
        end else if (v >= 6'd30) begin
            tens = 3'd3;
        end else if (v >= 6'd20) begin
            tens = 3'd2;
        end else if (v >= 6'd10) begin
            tens = 3'd1;
        end else begin
            tens = 3'd0;
        end
        ones = v - 6'(tens) * 6'd10;
        return {CH_ZERO + 8'(tens), CH_ZERO + 8'(ones[3:0])};
    endfunction

    function automatic logic [63:0] render(input logic [4:0] h, input logic [5:0] m,
                                           input logic [5:0] s, input logic en);
        if (en) begin
            return {digit_pair(6'(h)), CH_COLON, digit_pair(m), CH_COLON, digit_pair(s)};
        end
        return {8{CH_SPACE}};
    endfunction

    // take a command when the result slot is free or being drained
    assign take      = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_pop = take;

    // apply the command
    always_comb begin
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_disp   = r_disp;
        case (i_cmd.op)
            OP_TICK: begin
                if (r_second == MAX_SECOND) begin
                    n_second = '0;
                    if (r_minute == MAX_MINUTE) begin
                        n_minute = '0;
                        n_hour   = (r_hour == MAX_HOUR) ? '0 : r_hour + 5'd1;
                    end else begin
                        n_minute = r_minute + 6'd1;
                    end
                end else begin
                    n_second = r_second + 6'd1;
                end
            end
            OP_RESET: begin
                n_hour   = '0;
                n_minute = '0;
                n_second = '0;
            end
            OP_SET: begin
                n_hour   = i_cmd.hour;
                n_minute = i_cmd.minute;
                n_second = i_cmd.second;
            end
            OP_TOGGLE: n_disp = !r_disp;
            default: ;
        endcase
    end

    // time state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_disp   <= 1'b1;
        end else if (take) begin
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_disp   <= n_disp;
        end
    end

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status <= (i_cmd.op == OP_ERROR);
            r_text   <= render(n_hour, n_minute, n_second, n_disp);
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_status       = r_status;
    assign o_display_text = r_text;

    // time stays a valid time of day
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hour <= MAX_HOUR) && (r_minute <= MAX_MINUTE) && (r_second <= MAX_SECOND))
        else $error("time out of range");

    // a tick below the minute boundary adds one second and keeps the rest
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (i_cmd.op == OP_TICK) && (r_second != MAX_SECOND)
        |=> (r_second == $past(r_second) + 6'd1) && $stable(r_minute) && $stable(r_hour))
        else $error("tick did not advance seconds");

    // toggle flips the display flag
    a_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (i_cmd.op == OP_TOGGLE) |=> (r_disp != $past(r_disp)))
        else $error("toggle did not flip display");

    // an error leaves the state unchanged and is reported
    a_error_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (i_cmd.op == OP_ERROR)
        |=> $stable(r_hour) && $stable(r_minute) && $stable(r_second) && $stable(r_disp)
            && r_status && r_out_valid)
        else $error("error command changed state");

endmodule

// File: hw/rtl/settable_time_of_day_clock_core.sv
// ----------------------------------------------------------------------------
// settable_time_of_day_clock_core
// 24-hour time-of-day clock with a display flag, driven by one-second ticks
// and reset, set and toggle command messages.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while full is low and returns one result
// per item, status plus the HH:MM:SS text (or eight spaces with the display
// off) as it stands after the item. An accepted item passes through the
// command queue and then the result register before its result is visible
// and can be popped. The sustained rate of one item per cycle, while pop
// keeps up, is set by the back end, which applies one command per cycle and
// refills the result register in the same cycle that it is popped; while pop
// is held low the queue of QUEUE_DEPTH entries fills and then full is raised.
module settable_time_of_day_clock_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [7:0]  i_message_length,
    input  logic [7:0]  i_command_char,
    input  logic [7:0]  i_hour_tens_char,
    input  logic [7:0]  i_hour_ones_char,
    input  logic [7:0]  i_first_separator,
    input  logic [7:0]  i_minute_tens_char,
    input  logic [7:0]  i_minute_ones_char,
    input  logic [7:0]  i_second_separator,
    input  logic [7:0]  i_second_tens_char,
    input  logic [7:0]  i_second_ones_char,
    output logic        empty,
    input  logic        pop,
    output logic        o_status,
    output logic [63:0] o_display_text
);
    import stc_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_valid;
    logic queue_pop;

    // classify the incoming item
    stc_front u_front (
        .i_mode             (i_mode),
        .i_message_length   (i_message_length),
        .i_command_char     (i_command_char),
        .i_hour_tens_char   (i_hour_tens_char),
        .i_hour_ones_char   (i_hour_ones_char),
        .i_first_separator  (i_first_separator),
        .i_minute_tens_char (i_minute_tens_char),
        .i_minute_ones_char (i_minute_ones_char),
        .i_second_separator (i_second_separator),
        .i_second_tens_char (i_second_tens_char),
        .i_second_ones_char (i_second_ones_char),
        .o_cmd              (front_cmd)
    );

    // command queue
    stc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    // execute and render
    stc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (queue_valid),
        .i_cmd          (queue_cmd),
        .o_cmd_pop      (queue_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_status       (o_status),
        .o_display_text (o_display_text)
    );

endmodule
